// ----- rtl/sfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_pkg: shared definitions for the stereo feedback echo
// Constants, register indexes, link types and the soft-clip table builder.
// ----------------------------------------------------------------------------
package sfe_pkg;

   localparam int LINE_DEPTH_DEF      = 131072;
   localparam int CLIP_TABLE_SIZE_DEF = 1024;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 15;
   localparam int DELAY_W  = 25;
   localparam int SUM_W    = 27;
   localparam int CSR_IDX_W = 3;

   // Unsigned Q1.14 loop gains: 0.95 on the input, 0.985 in freeze
   localparam logic [GAIN_W-1:0] INPUT_FEED   = 15'd15565;
   localparam logic [GAIN_W-1:0] FREEZE_REGEN = 15'd16138;

   // result queue depth, also the limit on words in flight
   localparam int OUT_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LEFT  = 3'd0,
      CSR_DELAY_RIGHT = 3'd1,
      CSR_DRY_GAIN    = 3'd2,
      CSR_WET_GAIN    = 3'd3,
      CSR_REGEN_GAIN  = 3'd4,
      CSR_FREEZE_ON   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic freeze;
   } lane_ctl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } out_word_type;

   // truncating 64-bit quotient by shift and subtract
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned q;
      longint unsigned rem;
      int b;
      q   = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem  = rem - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(4i/(n-1)) in Q1.23, used to fill the clip table
   function automatic logic [SAMPLE_W-1:0] clip_entry(input int idx, input int n);
      longint unsigned one;
      longint unsigned den;
      longint unsigned z;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned e;
      longint unsigned num;
      longint unsigned dd;
      longint unsigned t;
      bit minus;
      int k;
      one   = 64'd1 << 30;
      den   = 64'(2 * (n - 1));
      z     = div_u64(64'(idx) << 30, den);
      term  = one;
      sum   = one;
      minus = 1'b1;
      for (k = 1; k <= 24; k++) begin
         term = div_u64(term * z, 64'(k) << 30);
         if (minus) sum = sum - term;
         else       sum = sum + term;
         minus = !minus;
      end
      e = (sum > one) ? one : sum;
      for (k = 0; k < 4; k++) begin
         e = (e * e) >> 30;
      end
      num = (one - e) << 23;
      dd  = one + e;
      t   = div_u64(num + (dd >> 1), dd);
      if (t > 64'd8388607) t = 64'd8388607;
      return t[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- rtl/sfe_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_req_if: input sample channel
// Valid/ready channel carrying one stereo input word.
// ----------------------------------------------------------------------------
interface sfe_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sfe_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [sfe_pkg::SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- rtl/sfe_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_rsp_if: output sample channel
// Valid/ready channel carrying one stereo result word.
// ----------------------------------------------------------------------------
interface sfe_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [sfe_pkg::SAMPLE_W-1:0] left_out;
   logic signed [sfe_pkg::SAMPLE_W-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/stereo_feedback_echo_freeze_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_feedback_echo_freeze_core: stereo feedback delay with soft clip
// Two interpolated delay lines with freeze, tanh saturation and dry/wet mix.
// ----------------------------------------------------------------------------
// The core takes at most one stereo word per issue slot, may take a new word
// before the last is through, and returns one result word per input word, in
// order. The pace is set by the single port of each channel's delay memory:
// each word reads the two interpolation taps and writes the new loop sample
// back, and words enter only at the start of an issue slot so the write-back
// of one word lands in the free slot between the reads of the next ones. Up to
// 4 words may be in flight or waiting in the result queue; the input stalls
// beyond that. The delay memories are not swept at reset: a fill count of
// words written makes taps that reach past written history read as zero, so
// the core is ready once reset is released. Configuration is to be written
// through the csr port while no word is in flight; the core does not check it.
module stereo_feedback_echo_freeze_core #(
   parameter int LINE_DEPTH      = sfe_pkg::LINE_DEPTH_DEF,
   parameter int CLIP_TABLE_SIZE = sfe_pkg::CLIP_TABLE_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sfe_req_if.sink                              req_ch,
   sfe_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [sfe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sfe_pkg::DELAY_W-1:0]          csr_wdata
);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int QW = $clog2(sfe_pkg::OUT_DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(LINE_DEPTH);
   localparam logic [AW-1:0] WP_TOP  = AW'(LINE_DEPTH - 1);
   localparam logic [QW:0]   QFULL   = (QW + 1)'(sfe_pkg::OUT_DEPTH);

   // configuration registers
   logic [sfe_pkg::DELAY_W-1:0] delay_left_ff, delay_right_ff;
   logic [sfe_pkg::GAIN_W-1:0]  dry_gain_ff, wet_gain_ff, regen_gain_ff;
   logic                        freeze_on_ff;

   // issue slot, shared write pointer and fill count
   logic [1:0]    phase_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          accept;

   // words accepted but not yet delivered, and the result queue
   logic [QW:0]   occ_ff, occ_in;
   logic [QW:0]   cnt_ff, cnt_in;
   logic [QW-1:0] wr_ptr_ff, rd_ptr_ff;
   sfe_pkg::out_word_type queue [sfe_pkg::OUT_DEPTH];
   logic          push, pop;

   sfe_pkg::lane_ctl_type ctl;
   logic l_vld, r_vld, l_wr, r_wr;
   logic signed [sfe_pkg::SAMPLE_W-1:0] l_out, r_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff  <= 25'd2211840;
         delay_right_ff <= 25'd2334720;
         dry_gain_ff    <= 15'd8866;
         wet_gain_ff    <= 15'd20440;
         regen_gain_ff  <= 15'd5862;
         freeze_on_ff   <= 1'b0;
      end else if (csr_we) begin
         case (sfe_pkg::csr_index_type'(csr_index))
            sfe_pkg::CSR_DELAY_LEFT:  delay_left_ff  <= csr_wdata;
            sfe_pkg::CSR_DELAY_RIGHT: delay_right_ff <= csr_wdata;
            sfe_pkg::CSR_DRY_GAIN:    dry_gain_ff    <= csr_wdata[sfe_pkg::GAIN_W-1:0];
            sfe_pkg::CSR_WET_GAIN:    wet_gain_ff    <= csr_wdata[sfe_pkg::GAIN_W-1:0];
            sfe_pkg::CSR_REGEN_GAIN:  regen_gain_ff  <= csr_wdata[sfe_pkg::GAIN_W-1:0];
            sfe_pkg::CSR_FREEZE_ON:   freeze_on_ff   <= csr_wdata[0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // accept only at slot start and while the queue can absorb the result
   assign req_ch.ready = (phase_ff == 2'd0) && (occ_ff < QFULL);
   assign accept       = req_ch.valid && req_ch.ready;

   // pointer moves down one entry per word, fill saturates at the depth
   assign wp_in   = (wp_ff == '0) ? WP_TOP : wp_ff - AW'(1);
   assign fill_in = (fill_ff == DEPTH_W) ? fill_ff : fill_ff + (AW + 1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         phase_ff <= phase_ff + 2'd1;
         if (accept) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
      end
   end

   assign ctl.start  = accept;
   assign ctl.freeze = freeze_on_ff;

   sfe_lane #(.LINE_DEPTH(LINE_DEPTH), .CLIP_TABLE_SIZE(CLIP_TABLE_SIZE)) u_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .delay      (delay_left_ff),
      .wp         (wp_ff),
      .fill       (fill_ff),
      .sample     (req_ch.left_sample),
      .dry_gain   (dry_gain_ff),
      .wet_gain   (wet_gain_ff),
      .regen_gain (regen_gain_ff),
      .out_vld    (l_vld),
      .out_sample (l_out),
      .wr_vld     (l_wr)
   );

   sfe_lane #(.LINE_DEPTH(LINE_DEPTH), .CLIP_TABLE_SIZE(CLIP_TABLE_SIZE)) u_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .delay      (delay_right_ff),
      .wp         (wp_ff),
      .fill       (fill_ff),
      .sample     (req_ch.right_sample),
      .dry_gain   (dry_gain_ff),
      .wet_gain   (wet_gain_ff),
      .regen_gain (regen_gain_ff),
      .out_vld    (r_vld),
      .out_sample (r_out),
      .wr_vld     (r_wr)
   );

   // both lanes run in lockstep; both valids together mark a finished word
   assign push = l_vld && r_vld;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      occ_in = occ_ff;
      if (accept && !pop)      occ_in = occ_ff + (QW + 1)'(1);
      else if (!accept && pop) occ_in = occ_ff - (QW + 1)'(1);
      cnt_in = cnt_ff;
      if (push && !pop)        cnt_in = cnt_ff + (QW + 1)'(1);
      else if (!push && pop)   cnt_in = cnt_ff - (QW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         occ_ff <= occ_in;
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + QW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue[wr_ptr_ff] <= '{left_out: l_out, right_out: r_out};
      end
   end

   assign rsp_ch.valid     = (cnt_ff != '0);
   assign rsp_ch.left_out  = queue[rd_ptr_ff].left_out;
   assign rsp_ch.right_out = queue[rd_ptr_ff].right_out;

   // a finished word always finds room in the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> cnt_ff < QFULL)
      else $error("result queue overflow");

   // queued words never outnumber words in flight
   a_queue_le_occ: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= occ_ff)
      else $error("queue holds more words than accepted");

   // write-back must use the slot left free by the reads
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      (l_wr || r_wr) |-> phase_ff == 2'd3)
      else $error("memory write-back outside its slot");

   // lanes never drift apart
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      l_vld == r_vld)
      else $error("lane results out of step");

endmodule

// ----- rtl/sfe_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_clip: table-based tanh soft clipper
// Two register stages; the final add and sign are combinational.
// ----------------------------------------------------------------------------
module sfe_clip #(
   parameter int CLIP_TABLE_SIZE = sfe_pkg::CLIP_TABLE_SIZE_DEF
) (
   input  logic                                clock,
   input  logic signed [sfe_pkg::SUM_W-1:0]    value,
   output logic signed [sfe_pkg::SAMPLE_W-1:0] clipped
);
   localparam int IW = $clog2(CLIP_TABLE_SIZE);
   localparam int PW = 26 + IW;
   localparam logic [IW-1:0] LAST = IW'(CLIP_TABLE_SIZE - 1);
   localparam logic signed [sfe_pkg::SUM_W-1:0] LIMIT = sfe_pkg::SUM_W'(33554432);

   logic [sfe_pkg::SAMPLE_W-1:0] clip_rom [CLIP_TABLE_SIZE];

   logic signed [sfe_pkg::SUM_W-1:0] clamp_val;
   logic [25:0]                      mag;
   logic [PW-1:0]                    scaled;
   logic                             neg_in, neg1_ff, neg2_ff;
   logic [IW-1:0]                    idx0, idx1;
   logic [24:0]                      frac_ff;
   logic [sfe_pkg::SAMPLE_W-1:0]     t0_ff, t1_ff, base_ff;
   logic signed [24:0]               diff;
   logic signed [50:0]               dr_in, dr_ff;
   logic signed [25:0]               y_full;

   // fixed tanh table
   initial begin
      for (int i = 0; i < CLIP_TABLE_SIZE; i++) begin
         clip_rom[i] = sfe_pkg::clip_entry(i, CLIP_TABLE_SIZE);
      end
   end

   // stage 1: clamp to +-4.0, scale magnitude onto the table, pick the segment
   always_comb begin
      if (value > LIMIT)       clamp_val = LIMIT;
      else if (value < -LIMIT) clamp_val = -LIMIT;
      else                     clamp_val = value;
      neg_in = clamp_val[sfe_pkg::SUM_W-1];
      mag    = neg_in ? 26'(-clamp_val) : 26'(clamp_val);
      scaled = PW'(mag) * PW'(LAST);
      idx0   = scaled[25 +: IW];
      idx1   = (idx0 == LAST) ? idx0 : idx0 + IW'(1);
   end

   always_ff @(posedge clock) begin
      t0_ff   <= clip_rom[idx0];
      t1_ff   <= clip_rom[idx1];
      frac_ff <= scaled[24:0];
      neg1_ff <= neg_in;
   end

   // stage 2: weight the slope
   always_comb begin
      diff  = $signed({1'b0, t1_ff}) - $signed({1'b0, t0_ff});
      dr_in = diff * $signed({1'b0, frac_ff});
   end

   always_ff @(posedge clock) begin
      dr_ff   <= dr_in;
      base_ff <= t0_ff;
      neg2_ff <= neg1_ff;
   end

   // stage 3: add the fraction, restore the sign
   always_comb begin
      y_full  = $signed({2'b00, base_ff}) + dr_ff[25 +: 26];
      clipped = neg2_ff ? -y_full[sfe_pkg::SAMPLE_W-1:0] : y_full[sfe_pkg::SAMPLE_W-1:0];
   end

endmodule

// ----- rtl/sfe_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfe_lane: one channel of the echo
// Delay memory, interpolated read, loop write-back and output mix.
// ----------------------------------------------------------------------------
module sfe_lane #(
   parameter  int LINE_DEPTH      = sfe_pkg::LINE_DEPTH_DEF,
   parameter  int CLIP_TABLE_SIZE = sfe_pkg::CLIP_TABLE_SIZE_DEF,
   localparam int AW              = $clog2(LINE_DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sfe_pkg::lane_ctl_type               ctl,
   input  logic [sfe_pkg::DELAY_W-1:0]         delay,
   input  logic [AW-1:0]                       wp,
   input  logic [AW:0]                         fill,
   input  logic signed [sfe_pkg::SAMPLE_W-1:0] sample,
   input  logic [sfe_pkg::GAIN_W-1:0]          dry_gain,
   input  logic [sfe_pkg::GAIN_W-1:0]          wet_gain,
   input  logic [sfe_pkg::GAIN_W-1:0]          regen_gain,
   output logic                                out_vld,
   output logic signed [sfe_pkg::SAMPLE_W-1:0] out_sample,
   output logic                                wr_vld
);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(LINE_DEPTH);
   localparam logic [26:0] DLY_LO  = 27'd512;
   localparam logic [26:0] DLY_HI  = 27'((LINE_DEPTH - 4) * 256);

   logic [sfe_pkg::SAMPLE_W-1:0] mem [LINE_DEPTH];
   logic [sfe_pkg::SAMPLE_W-1:0] rd_ff;

   logic [7:1]  vld_ff, vld_in;
   logic [26:0] dly_x, dcl;
   logic [AW-1:0] dint, addr_a, addr_b, mem_addr;
   logic [AW:0] sum_a, sum_b;
   logic        va, vb, mem_we;

   logic [AW-1:0] addr_b_ff, wp_ff, wp4_ff;
   logic          va_ff, vb_ff;
   logic [7:0]    frac_ff;
   logic signed [sfe_pkg::SAMPLE_W-1:0] smp_ff, a_ff, x_ff, b_val;
   logic signed [24:0] diff;
   logic signed [33:0] prod_ff;
   logic signed [34:0] rnd;
   logic signed [25:0] x_in;
   logic signed [40:0] pw, po;
   logic signed [39:0] pf;
   logic signed [sfe_pkg::SUM_W-1:0] wsum_ff, osum_ff;
   logic signed [sfe_pkg::SAMPLE_W-1:0] fz_ff, fz5_ff, fz6_ff, wclip, wdata;

   // read addresses for the two taps, and whether they hold written data
   always_comb begin
      dly_x  = {2'b00, delay};
      if (dly_x < DLY_LO)      dcl = DLY_LO;
      else if (dly_x > DLY_HI) dcl = DLY_HI;
      else                     dcl = dly_x;
      dint   = dcl[8 +: AW];
      sum_a  = {1'b0, wp} + {1'b0, dint};
      addr_a = (sum_a >= DEPTH_W) ? AW'(sum_a - DEPTH_W) : sum_a[AW-1:0];
      sum_b  = {1'b0, addr_a} + (AW + 1)'(1);
      addr_b = (sum_b == DEPTH_W) ? '0 : sum_b[AW-1:0];
      va     = {1'b0, dint} <= fill;
      vb     = ({1'b0, dint} + (AW + 1)'(1)) <= fill;
   end

   assign vld_in = {vld_ff[6:1], ctl.start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // single port: write-back in the slot after the next word's reads
   assign mem_we   = vld_ff[7];
   assign mem_addr = mem_we ? wp4_ff : (ctl.start ? addr_a : addr_b_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wdata;
      end else begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         addr_b_ff <= addr_b;
         va_ff     <= va;
         vb_ff     <= vb;
         frac_ff   <= dcl[7:0];
         smp_ff    <= sample;
         wp_ff     <= wp;
      end
      if (vld_ff[1]) begin
         a_ff <= va_ff ? $signed(rd_ff) : '0;
      end
      if (vld_ff[2]) begin
         prod_ff <= diff * $signed({1'b0, frac_ff});
      end
      if (vld_ff[3]) begin
         x_ff <= x_in[sfe_pkg::SAMPLE_W-1:0];
      end
      if (vld_ff[4]) begin
         wsum_ff <= pw[14 +: sfe_pkg::SUM_W];
         osum_ff <= po[14 +: sfe_pkg::SUM_W];
         fz_ff   <= pf[14 +: sfe_pkg::SAMPLE_W];
         wp4_ff  <= wp_ff;
      end
      if (vld_ff[5]) begin
         fz5_ff <= fz_ff;
      end
      if (vld_ff[6]) begin
         fz6_ff <= fz5_ff;
      end
   end

   // interpolate, then form loop and output sums
   always_comb begin
      b_val = vb_ff ? $signed(rd_ff) : '0;
      diff  = {b_val[sfe_pkg::SAMPLE_W-1], b_val} - {a_ff[sfe_pkg::SAMPLE_W-1], a_ff};
      rnd   = {prod_ff[33], prod_ff} + 35'sd128;
      x_in  = {{2{a_ff[sfe_pkg::SAMPLE_W-1]}}, a_ff} + rnd[8 +: 26];
      pw    = 41'(smp_ff * $signed({1'b0, sfe_pkg::INPUT_FEED}))
            + 41'(x_ff * $signed({1'b0, regen_gain})) + 41'sd8192;
      po    = 41'(smp_ff * $signed({1'b0, dry_gain}))
            + 41'(x_ff * $signed({1'b0, wet_gain})) + 41'sd8192;
      pf    = 40'(x_ff * $signed({1'b0, sfe_pkg::FREEZE_REGEN})) + 40'sd8192;
   end

   sfe_clip #(.CLIP_TABLE_SIZE(CLIP_TABLE_SIZE)) u_wclip (
      .clock   (clock),
      .value   (wsum_ff),
      .clipped (wclip)
   );

   sfe_clip #(.CLIP_TABLE_SIZE(CLIP_TABLE_SIZE)) u_oclip (
      .clock   (clock),
      .value   (osum_ff),
      .clipped (out_sample)
   );

   assign wdata   = ctl.freeze ? fz6_ff : wclip;
   assign out_vld = vld_ff[7];
   assign wr_vld  = vld_ff[7];

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stereo feedback echo core
// Drives stereo words through the valid/ready channels over several register
// settings (short and long delays, saturated delays, gains over range,
// freeze). A bit-exact echo model holds its own delay lines and tanh table,
// and each returned word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int DEPTH    = sfe_pkg::LINE_DEPTH_DEF;
   localparam int TAB_N    = sfe_pkg::CLIP_TABLE_SIZE_DEF;
   localparam int SETTLE   = 24;   // cycles for the pipeline to drain
   localparam int HOLD_LEN = 300;  // long receiver hold-off

   typedef struct {
      logic [sfe_pkg::DELAY_W-1:0] dl;
      logic [sfe_pkg::DELAY_W-1:0] dr;
      logic [sfe_pkg::GAIN_W-1:0]  dry;
      logic [sfe_pkg::GAIN_W-1:0]  wet;
      logic [sfe_pkg::GAIN_W-1:0]  regen;
      logic                        frz;
      int                          words;
      bit                          squeeze;   // long hold-off on the result side
      bit                          drain_mid; // sender waits for the queue to empty
   } setting_type;

   typedef struct {
      logic signed [sfe_pkg::SAMPLE_W-1:0] l;
      logic signed [sfe_pkg::SAMPLE_W-1:0] r;
      bit                                  typed;
      logic signed [sfe_pkg::SAMPLE_W-1:0] el;
      logic signed [sfe_pkg::SAMPLE_W-1:0] er;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [sfe_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sfe_pkg::DELAY_W-1:0]   csr_wdata;

   sfe_req_if req_ch ();
   sfe_rsp_if rsp_ch ();

   stereo_feedback_echo_freeze_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // echo model state
   // ---------------------------------------------------------------------
   int                          tanh_tab [TAB_N];
   int                          left_hist [DEPTH];
   int                          right_hist [DEPTH];
   int unsigned                 head;
   logic [sfe_pkg::DELAY_W-1:0] m_dl, m_dr;
   logic [sfe_pkg::GAIN_W-1:0]  m_dry, m_wet, m_regen;
   logic                        m_frz;

   sfe_pkg::out_word_type echo_expected [$];

   int gap_pct, stall_pct;
   bit hold_active;
   event hold_kick;
   int words_sent, words_seen, mismatches;
   bit failed;

   // tanh(4i/(N-1)) in Q1.23 via exp(-z)^16 and a truncated Taylor series
   function automatic int tanh_point(int idx);
      longint unsigned one, z, term, acc, e, num, dd, t;
      bit neg_term;
      one = 64'd1 << 30;
      z = (longint'(idx) << 30) / longint'(2 * (TAB_N - 1));
      term = one;
      acc = one;
      neg_term = 1'b1;
      for (int n = 1; n <= 24; n++) begin
         term = (term * z) / (longint'(n) << 30);
         acc = neg_term ? acc - term : acc + term;
         neg_term = !neg_term;
      end
      e = (acc > one) ? one : acc;
      repeat (4) e = (e * e) >> 30;
      num = (one - e) << 23;
      dd = one + e;
      t = (num + dd / 2) / dd;
      if (t > 64'd8388607) t = 64'd8388607;
      return int'(t);
   endfunction

   function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] tanh_sat(longint v);
      longint m, p, i, r, y, d;
      bit neg;
      if (v > (64'sd1 <<< 25)) v = 64'sd1 <<< 25;
      if (v < -(64'sd1 <<< 25)) v = -(64'sd1 <<< 25);
      neg = v < 0;
      m = neg ? -v : v;
      p = m * (TAB_N - 1);
      i = p >>> 25;
      if (i >= TAB_N - 1) begin
         y = tanh_tab[TAB_N-1];
      end else begin
         r = p & ((64'sd1 <<< 25) - 1);
         d = longint'(tanh_tab[i+1]) - tanh_tab[i];
         y = tanh_tab[i] + ((d * r) >>> 25);
      end
      if (neg) y = -y;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[sfe_pkg::SAMPLE_W-1:0];
   endfunction

   function automatic longint mix_q14(longint s1, longint g1, longint s2, longint g2);
      return (s1 * g1 + s2 * g2 + 8192) >>> 14;
   endfunction

   function automatic longint tap_read(bit right_side, logic [sfe_pkg::DELAY_W-1:0] dly);
      longint unsigned lo, hi, d;
      int unsigned i0, i1;
      longint a, b;
      lo = 512;
      hi = longint'(DEPTH - 4) * 256;
      d = dly;
      if (d < lo) d = lo;
      if (d > hi) d = hi;
      i0 = (head + int'(d >> 8)) % DEPTH;
      i1 = (i0 + 1) % DEPTH;
      a = right_side ? right_hist[i0] : left_hist[i0];
      b = right_side ? right_hist[i1] : left_hist[i1];
      return a + (((b - a) * longint'(d & 8'hFF) + 128) >>> 8);
   endfunction

   // advance the echo model by one accepted word, return the predicted output
   function automatic sfe_pkg::out_word_type predict_echo(
         logic signed [sfe_pkg::SAMPLE_W-1:0] il,
         logic signed [sfe_pkg::SAMPLE_W-1:0] ir);
      longint a, b;
      sfe_pkg::out_word_type w;
      a = tap_read(1'b0, m_dl);
      b = tap_read(1'b1, m_dr);
      if (m_frz) begin
         left_hist[head]  = int'(mix_q14(a, sfe_pkg::FREEZE_REGEN, 0, 0));
         right_hist[head] = int'(mix_q14(b, sfe_pkg::FREEZE_REGEN, 0, 0));
      end else begin
         left_hist[head]  = tanh_sat(mix_q14(il, sfe_pkg::INPUT_FEED, a, m_regen));
         right_hist[head] = tanh_sat(mix_q14(ir, sfe_pkg::INPUT_FEED, b, m_regen));
      end
      head = (head == 0) ? DEPTH - 1 : head - 1;
      w.left_out  = tanh_sat(mix_q14(il, m_dry, a, m_wet));
      w.right_out = tanh_sat(mix_q14(ir, m_dry, b, m_wet));
      return w;
   endfunction

   function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'(int'($urandom_range(0, 2000)) - 1000);
         default: return 24'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // clock, hold-off timer, result side
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // count the long hold-off in its own process; flip at posedge so the
   // negedge ready driver sees a stable value
   initial begin
      hold_active = 1'b0;
      forever begin
         @(hold_kick);
         @(posedge clock);
         hold_active = 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !hold_active && ($urandom_range(0, 99) >= stall_pct);
   end

   // check every accepted word against the oldest prediction
   always @(posedge clock) begin
      sfe_pkg::out_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_seen++;
         if (echo_expected.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] unexpected word L=%0d R=%0d", $realtime,
                        rsp_ch.left_out, rsp_ch.right_out);
         end else begin
            want = echo_expected.pop_front();
            if (rsp_ch.left_out !== want.left_out || rsp_ch.right_out !== want.right_out) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] word %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
                           $realtime, words_seen, want.left_out, want.right_out,
                           rsp_ch.left_out, rsp_ch.right_out);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // input side; called at a falling edge, returns at a falling edge
   // ---------------------------------------------------------------------
   task automatic offer_word(input logic signed [sfe_pkg::SAMPLE_W-1:0] l,
                             input logic signed [sfe_pkg::SAMPLE_W-1:0] r,
                             input bit typed,
                             input sfe_pkg::out_word_type typed_word);
      sfe_pkg::out_word_type w;
      // drop valid for a random gap
      while ($urandom_range(0, 99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= l;
      req_ch.right_sample <= r;
      // hold until the core takes the word
      do @(posedge clock); while (!req_ch.ready);
      w = predict_echo(l, r);
      echo_expected.push_back(typed ? typed_word : w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (echo_expected.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write all six registers back to back, then lower the strobe
   task automatic load_setting(input setting_type s);
      logic [sfe_pkg::DELAY_W-1:0] vals [6];
      sfe_pkg::csr_index_type regs [6];
      vals = '{s.dl, s.dr, sfe_pkg::DELAY_W'(s.dry), sfe_pkg::DELAY_W'(s.wet),
               sfe_pkg::DELAY_W'(s.regen), sfe_pkg::DELAY_W'(s.frz)};
      regs = '{sfe_pkg::CSR_DELAY_LEFT, sfe_pkg::CSR_DELAY_RIGHT, sfe_pkg::CSR_DRY_GAIN,
               sfe_pkg::CSR_WET_GAIN, sfe_pkg::CSR_REGEN_GAIN, sfe_pkg::CSR_FREEZE_ON};
      for (int k = 0; k < 6; k++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[k];
         csr_wdata <= vals[k];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      m_dl = s.dl; m_dr = s.dr;
      m_dry = s.dry; m_wet = s.wet; m_regen = s.regen; m_frz = s.frz;
   endtask

   // ---------------------------------------------------------------------
   // limit
   // ---------------------------------------------------------------------
   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type          rows [$];
      setting_type           plan [$];
      setting_type           s;
      sfe_pkg::out_word_type tw;
      int                    idle_mode;

      req_ch.valid = 1'b0;
      req_ch.left_sample = '0;
      req_ch.right_sample = '0;
      csr_we = 1'b0;
      csr_index = sfe_pkg::CSR_DELAY_LEFT;
      csr_wdata = '0;
      gap_pct = 0;
      stall_pct = 0;
      words_sent = 0;
      words_seen = 0;
      mismatches = 0;
      failed = 1'b0;

      // model after reset: empty lines, default registers
      foreach (tanh_tab[i]) tanh_tab[i] = tanh_point(i);
      foreach (left_hist[i]) begin
         left_hist[i] = 0;
         right_hist[i] = 0;
      end
      head = 0;
      m_dl = 25'd2211840; m_dr = 25'd2334720;
      m_dry = 15'd8866; m_wet = 15'd20440; m_regen = 15'd5862; m_frz = 1'b0;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at reset settings; the taps still see empty history,
      // so silence in gives silence out
      rows = '{
         '{24'sd0,        24'sd0,        1, 24'sd0, 24'sd0},
         '{24'sh7FFFFF,   24'sh7FFFFF,   0, 0, 0},
         '{24'sh800000,   24'sh800000,   0, 0, 0},
         '{24'sh7FFFFF,   24'sh800000,   0, 0, 0},
         '{24'sh800000,   24'sh7FFFFF,   0, 0, 0},
         '{24'sd1,        -24'sd1,       0, 0, 0},
         '{-24'sd1,       24'sd1,        0, 0, 0},
         '{24'sh555555,   24'shAAAAAA,   0, 0, 0},
         '{24'shAAAAAA,   24'sh555555,   0, 0, 0},
         '{24'sh400000,   -24'sh400000,  0, 0, 0},
         '{24'sd0,        24'sd0,        1, 24'sd0, 24'sd0},
         '{24'sh123456,   24'shEDCBA9,   0, 0, 0},
         '{24'sh0000FF,   24'shFFFF00,   0, 0, 0},
         '{24'sh7FFFFE,   24'sh800001,   0, 0, 0}
      };
      foreach (rows[i]) begin
         tw.left_out = rows[i].el;
         tw.right_out = rows[i].er;
         offer_word(rows[i].l, rows[i].r, rows[i].typed, tw);
      end
      req_ch.valid <= 1'b0;
      wait_drained();

      // register settings; extremes of delay and gain among them
      plan = '{
         '{25'd512,      25'd700,      15'd16384, 15'd16384, 15'd16384, 1'b0, 150, 0, 0},
         '{25'd0,        25'd1187,     15'd8866,  15'd20440, 15'd5862,  1'b0, 150, 0, 1},
         '{25'h1FFFFFF,  25'd33553408, 15'd0,     15'd22118, 15'd0,     1'b0, 60,  0, 0},
         '{25'd3071,     25'd3210,     15'd16384, 15'd22118, 15'd16384, 1'b1, 150, 0, 0},
         '{25'd1500,     25'd2333,     15'h7FFF,  15'h7FFF,  15'h7FFF,  1'b0, 120, 0, 0},
         '{25'd777,      25'd1029,     15'd12000, 15'd16000, 15'd10000, 1'b0, 200, 1, 0},
         '{25'd700,      25'd900,      15'd8000,  15'd20000, 15'd12000, 1'b1, 100, 0, 1},
         '{25'd0,        25'd0,        15'd0,     15'd0,     15'd0,     1'b0, 120, 0, 0}
      };
      // last setting draws random short delays and gains
      plan[7].dl = sfe_pkg::DELAY_W'($urandom_range(512, 20000));
      plan[7].dr = sfe_pkg::DELAY_W'($urandom_range(512, 20000));
      plan[7].dry = sfe_pkg::GAIN_W'($urandom_range(0, 32767));
      plan[7].wet = sfe_pkg::GAIN_W'($urandom_range(0, 32767));
      plan[7].regen = sfe_pkg::GAIN_W'($urandom_range(0, 16384));

      foreach (plan[p]) begin
         s = plan[p];
         load_setting(s);
         // rotate idling: none, sender gaps, receiver stalls, both
         idle_mode = p % 4;
         gap_pct   = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 38 : 0;
         stall_pct = (idle_mode == 2) ? 46 : (idle_mode == 3) ? 38 : 0;
         if (s.squeeze) -> hold_kick;
         for (int n = 0; n < s.words; n++) begin
            // pause until every expected word is back
            if (s.drain_mid && n == s.words / 2) begin
               req_ch.valid <= 1'b0;
               while (echo_expected.size() != 0) @(negedge clock);
            end
            offer_word(pick_sample(), pick_sample(), 1'b0, tw);
         end
         req_ch.valid <= 1'b0;
         wait_drained();
      end

      $display("Covered %0d words over %0d register settings (saturated delays,", words_sent,
               plan.size() + 1);
      $display("gains over range, freeze on and off) with %0d mismatches.", mismatches);
      if (!failed && echo_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
